// ===== rtl/core/mhpq_pkg.sv =====
// shared types and constants of the min-heap priority queue
// no dependencies; used by the interfaces, the controller and the top level
package mhpq_pkg;

  localparam int KEY_W = 32;

  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_EXTRACT = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_LOAD    = 3'd3,
    KIND_HEAPIFY = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // finished operation handed from the controller to the output register
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] min_key;
    status_e                 status;
  } done_t;

endpackage

// ===== rtl/core/mhpq_if.sv =====
// request and result channel interfaces of the min-heap priority queue
// depends on mhpq_pkg for the key width
interface mhpq_req_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       kind;
  logic signed [mhpq_pkg::KEY_W-1:0] key_value;

  modport source (output valid, kind, key_value, input ready);
  modport sink   (input valid, kind, key_value, output ready);
endinterface

interface mhpq_rsp_if #(
  parameter int CNT_W = 9
);
  logic                             valid;
  logic                             ready;
  logic signed [mhpq_pkg::KEY_W-1:0] min_key;
  logic [1:0]                       status;
  logic [CNT_W-1:0]                 entry_count;

  modport source (output valid, min_key, status, entry_count, input ready);
  modport sink   (input valid, min_key, status, entry_count, output ready);
endinterface

// ===== rtl/core/mhpq_ram.sv =====
// key memory of the heap: one write port, one read port, registered read data
// depends on mhpq_pkg for the key width
module mhpq_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [mhpq_pkg::KEY_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [mhpq_pkg::KEY_W-1:0] rdata
);

  logic signed [mhpq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mhpq_ctrl.sv =====
// sequencer of the heap: decodes a request and runs sift-up, sift-down
// and heapify through the key memory; depends on mhpq_pkg
module mhpq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CNT_W    = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [2:0]                        req_kind,
  input  logic signed [mhpq_pkg::KEY_W-1:0] req_key,
  output mhpq_pkg::done_t                   done,
  input  logic                              done_ready,
  output logic [CNT_W-1:0]                  count,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic signed [mhpq_pkg::KEY_W-1:0] mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic signed [mhpq_pkg::KEY_W-1:0] mem_rdata
);

  localparam int CW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SU_RD, S_SU_CMP, S_EX_LAST, S_EX_KEY,
    S_SD_CHK, S_SD_L, S_SD_R, S_HP_NEXT, S_HP_KEY, S_DONE
  } state_t;

  state_t                            state;
  logic [AW-1:0]                     pos;
  logic signed [mhpq_pkg::KEY_W-1:0] cur_key;
  logic signed [mhpq_pkg::KEY_W-1:0] lkey;
  logic [CNT_W-1:0]                  hi;
  logic                              heapify;
  logic signed [mhpq_pkg::KEY_W-1:0] res_min;
  mhpq_pkg::status_e                 res_status;

  logic [CW-1:0]    child_l;
  logic [CW-1:0]    child_r;
  logic [CW-1:0]    n_ext;
  logic [AW-1:0]    pos_m1;
  logic [AW-1:0]    parent;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] hi_m1;
  logic             full;
  logic             l_ok;
  logic             r_ok;
  logic             take_l;
  logic signed [mhpq_pkg::KEY_W-1:0] bval;
  logic             take_r;

  assign child_l = {1'b0, pos, 1'b1};
  assign child_r = child_l + CW'(1);
  assign n_ext   = CW'(count);
  assign pos_m1  = pos - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign cnt_m1  = count - CNT_W'(1);
  assign hi_m1   = hi - CNT_W'(1);
  assign full    = (count >= CNT_W'(CAPACITY));
  assign l_ok    = (child_l < n_ext);
  assign r_ok    = (child_r < n_ext);
  // ties keep the parent, then the left child
  assign take_l  = (lkey < cur_key);
  assign bval    = take_l ? lkey : cur_key;
  assign take_r  = r_ok && (mem_rdata < bval);

  assign req_ready    = (state == S_IDLE);
  assign done.valid   = (state == S_DONE);
  assign done.min_key = res_min;
  assign done.status  = res_status;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur_key;
    mem_re    = 1'b0;
    mem_raddr = child_l[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (mhpq_pkg::kind_e'(req_kind))
            mhpq_pkg::KIND_LOAD: begin
              mem_we    = !full;
              mem_waddr = count[AW-1:0];
              mem_wdata = req_key;
            end
            mhpq_pkg::KIND_EXTRACT: begin
              mem_re    = (count != '0);
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_SU_RD: begin
        mem_we    = (pos == '0);
        mem_re    = (pos != '0);
        mem_raddr = parent;
      end
      S_SU_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata > cur_key) begin
          mem_wdata = mem_rdata;
        end
      end
      S_EX_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[AW-1:0];
      end
      S_SD_CHK: begin
        mem_we = !l_ok;
        mem_re = l_ok;
      end
      S_SD_L: begin
        mem_re    = r_ok;
        mem_raddr = child_r[AW-1:0];
      end
      S_SD_R: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = mem_rdata;
        end else if (take_l) begin
          mem_wdata = lkey;
        end
      end
      S_HP_NEXT: begin
        mem_re    = (hi != '0);
        mem_raddr = hi_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      heapify    <= 1'b0;
      res_min    <= '0;
      res_status <= mhpq_pkg::STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_min    <= '0;
            res_status <= mhpq_pkg::STATUS_OK;
            heapify    <= 1'b0;
            state      <= S_DONE;
            unique case (mhpq_pkg::kind_e'(req_kind))
              mhpq_pkg::KIND_INSERT: begin
                if (full) begin
                  res_status <= mhpq_pkg::STATUS_FULL;
                end else begin
                  pos     <= count[AW-1:0];
                  cur_key <= req_key;
                  count   <= count + CNT_W'(1);
                  state   <= S_SU_RD;
                end
              end
              mhpq_pkg::KIND_LOAD: begin
                if (full) begin
                  res_status <= mhpq_pkg::STATUS_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              mhpq_pkg::KIND_EXTRACT: begin
                if (count == '0) begin
                  res_status <= mhpq_pkg::STATUS_EMPTY;
                end else begin
                  state <= S_EX_LAST;
                end
              end
              mhpq_pkg::KIND_CLEAR: begin
                count <= '0;
              end
              mhpq_pkg::KIND_HEAPIFY: begin
                hi      <= count >> 1;
                heapify <= 1'b1;
                state   <= S_HP_NEXT;
              end
              default: ;
            endcase
          end
        end
        S_SU_RD: begin
          state <= (pos == '0) ? S_DONE : S_SU_CMP;
        end
        S_SU_CMP: begin
          if (mem_rdata > cur_key) begin
            pos   <= parent;
            state <= S_SU_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_EX_LAST: begin
          res_min <= mem_rdata;
          count   <= cnt_m1;
          state   <= S_EX_KEY;
        end
        S_EX_KEY: begin
          cur_key <= mem_rdata;
          pos     <= '0;
          state   <= (count == '0) ? S_DONE : S_SD_CHK;
        end
        S_SD_CHK: begin
          if (l_ok) begin
            state <= S_SD_L;
          end else begin
            state <= heapify ? S_HP_NEXT : S_DONE;
          end
        end
        S_SD_L: begin
          lkey  <= mem_rdata;
          state <= S_SD_R;
        end
        S_SD_R: begin
          if (take_r) begin
            pos   <= child_r[AW-1:0];
            state <= S_SD_CHK;
          end else if (take_l) begin
            pos   <= child_l[AW-1:0];
            state <= S_SD_CHK;
          end else begin
            state <= heapify ? S_HP_NEXT : S_DONE;
          end
        end
        S_HP_NEXT: begin
          if (hi == '0) begin
            state <= S_DONE;
          end else begin
            hi    <= hi_m1;
            pos   <= hi_m1[AW-1:0];
            state <= S_HP_KEY;
          end
        end
        S_HP_KEY: begin
          cur_key <= mem_rdata;
          state   <= S_SD_CHK;
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue of signed 32-bit keys, up to CAPACITY entries,
// held in one single-port-read, single-port-write memory with registered read data.
// Each request carries a kind: insert (append and sift up), extract minimum
// (return the root, move the last entry to the root and sift down), clear,
// raw load (append with no ordering) and heapify (sift down every parent from
// the last one back to the root); clear, raw loads and one heapify build a heap
// from a list. Every request gives exactly one result with the extracted key
// (zero unless an extract succeeded), a status (ok, empty on extract, full on
// insert or load with the key dropped) and the entry count afterwards. Unused
// kind codes change nothing and report ok. Requests are handled one at a time.
// A result waits in an output register, so the next request is taken and worked
// on while the previous result is still unclaimed.
// depends on mhpq_pkg, mhpq_if, mhpq_ram and mhpq_ctrl
module min_heap_priority_queue_top #(
  parameter int CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst,
  mhpq_req_if.sink       req,
  mhpq_rsp_if.source     rsp
);

  // address and count widths follow from the capacity
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // memory port between the sequencer and the key memory
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [mhpq_pkg::KEY_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic signed [mhpq_pkg::KEY_W-1:0] mem_rdata;

  // finished request and the entry count it leaves behind
  mhpq_pkg::done_t  done;
  logic             done_ready;
  logic [CNT_W-1:0] count;

  // output register
  logic                              out_valid;
  logic signed [mhpq_pkg::KEY_W-1:0] out_min;
  mhpq_pkg::status_e                 out_status;
  logic [CNT_W-1:0]                  out_count;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_kind   (req.kind),
    .req_key    (req.key_value),
    .done       (done),
    .done_ready (done_ready),
    .count      (count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // a new result may load when the register is empty or being emptied
  assign done_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ready) begin
      out_valid <= done.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (done_ready && done.valid) begin
      out_min    <= done.min_key;
      out_status <= done.status;
      out_count  <= count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.min_key     = out_min;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

endmodule

// ===== rtl/core/mhpq_chk.sv =====
// port-level checks of the min-heap priority queue, bound to the top level
// depends on mhpq_pkg and min_heap_priority_queue_top
module mhpq_chk #(
  parameter int CAPACITY = 256
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [mhpq_pkg::KEY_W-1:0] rsp_min_key,
  input logic [1:0]                        rsp_status,
  input logic [$clog2(CAPACITY+1)-1:0]     rsp_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // a stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_key)
      && $stable(rsp_status) && $stable(rsp_entry_count))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an empty extract leaves an empty heap and no key
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mhpq_pkg::STATUS_EMPTY
      |-> rsp_entry_count == '0 && rsp_min_key == '0)
    else $error("empty status with keys held");

  // a dropped key only happens at full capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mhpq_pkg::STATUS_FULL
      |-> rsp_entry_count == CNT_W'(CAPACITY) && rsp_min_key == '0)
    else $error("full status below capacity");

endmodule

bind min_heap_priority_queue_top mhpq_chk #(
  .CAPACITY (CAPACITY)
) u_mhpq_chk (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_min_key     (rsp.min_key),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count)
);

// ===== tb/testbench.sv =====
// self-checking testbench for min_heap_priority_queue_top
// depends on mhpq_pkg, mhpq_if and the queue rtl; holds its own heap predictor
// and runs directed, capacity, backpressure and randomized request sequences
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int HEAP_CAPACITY = 256;
  // kind codes the block leaves unused; they must change nothing
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam int LONG_HOLD    = 300;    // receiver hold-off during the backpressure test
  localparam int DRAIN_LIMIT  = 20000;  // worst case: full heapify plus a long stall
  localparam int SETTLE_TIME  = 64;     // settling time after the last result

  // one result of the queue as the predictor sees it
  typedef struct packed {
    logic signed [mhpq_pkg::KEY_W-1:0] min_key;
    mhpq_pkg::status_e                 status;
    logic [8:0]                        entry_count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  min_heap_priority_queue_top #(
    .CAPACITY(HEAP_CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state: array-backed heap mirroring the block
  logic signed [mhpq_pkg::KEY_W-1:0] heap_model [HEAP_CAPACITY];
  int unsigned                       model_count;

  // results predicted but not yet seen, oldest first
  heap_result_t pending_results [$];

  int error_count;
  int request_count;
  int result_count;
  int empty_extracts;
  int dropped_keys;
  int peak_count;
  int stall_cycles;

  // idling controls of the stimulus and the receiver process
  bit sender_idle_on;
  bit receiver_idle_on;
  bit long_hold_pending;
  int hold_left;
  int rx_gap_left;
  int rx_run_left;
  logic ready_next;

  // ---------------------------------------------------------------------------
  // heap predictor
  // ---------------------------------------------------------------------------

  // climb while the parent is strictly greater
  function automatic void model_sift_up(int unsigned pos);
    int unsigned parent;
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    bit done;
    done = 1'b0;
    while (pos > 0 && !done) begin
      parent = (pos - 1) / 2;
      if (heap_model[parent] <= heap_model[pos]) begin
        done = 1'b1;
      end else begin
        tmp               = heap_model[parent];
        heap_model[parent] = heap_model[pos];
        heap_model[pos]    = tmp;
        pos               = parent;
      end
    end
  endfunction

  // descend; ties keep the parent, then prefer the left child
  function automatic void model_sift_down(int unsigned pos);
    int unsigned best;
    int unsigned lchild;
    int unsigned rchild;
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    bit done;
    done = 1'b0;
    while (!done) begin
      best   = pos;
      lchild = 2 * pos + 1;
      rchild = 2 * pos + 2;
      if (lchild < model_count && heap_model[lchild] < heap_model[best]) best = lchild;
      if (rchild < model_count && heap_model[rchild] < heap_model[best]) best = rchild;
      if (best == pos) begin
        done = 1'b1;
      end else begin
        tmp             = heap_model[pos];
        heap_model[pos]  = heap_model[best];
        heap_model[best] = tmp;
        pos             = best;
      end
    end
  endfunction

  // apply one accepted request to the predictor and return its result
  function automatic heap_result_t apply_heap_op(logic [2:0] kind,
                                                 logic signed [mhpq_pkg::KEY_W-1:0] key);
    heap_result_t res;
    res.min_key = '0;
    res.status  = mhpq_pkg::STATUS_OK;
    case (kind) inside
      mhpq_pkg::KIND_INSERT, mhpq_pkg::KIND_LOAD: begin
        if (model_count >= HEAP_CAPACITY) begin
          res.status = mhpq_pkg::STATUS_FULL;
        end else begin
          heap_model[model_count] = key;
          model_count++;
          if (kind == mhpq_pkg::KIND_INSERT) model_sift_up(model_count - 1);
        end
      end
      mhpq_pkg::KIND_EXTRACT: begin
        if (model_count == 0) begin
          res.status = mhpq_pkg::STATUS_EMPTY;
        end else begin
          res.min_key   = heap_model[0];
          model_count--;
          heap_model[0] = heap_model[model_count];
          if (model_count > 0) model_sift_down(0);
        end
      end
      mhpq_pkg::KIND_CLEAR: begin
        model_count = 0;
      end
      mhpq_pkg::KIND_HEAPIFY: begin
        for (int unsigned i = model_count / 2; i > 0; i--) model_sift_down(i - 1);
      end
      default: ;
    endcase
    res.entry_count = model_count[8:0];
    return res;
  endfunction

  // keys: full random, a narrow band for ties, and the extremes
  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    logic signed [mhpq_pkg::KEY_W-1:0] key;
    case ($urandom_range(0, 5))
      0, 1: key = $urandom;
      2, 3: begin
        key = $urandom_range(0, 16);
        key = key - 8;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: key = KEY_MAX;
          1: key = KEY_MIN;
          2: key = '0;
          default: key = -1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) key = KEY_MAX - $urandom_range(0, 3);
        else key = KEY_MIN + $urandom_range(0, 3);
      end
    endcase
    return key;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] kind,
                              input logic signed [mhpq_pkg::KEY_W-1:0] key);
    int gap;
    heap_result_t predicted;
    // random idle burst before the request
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.kind      = kind;
    req_ch.key_value = key;
    req_ch.valid     = 1'b1;
    // hold the request until the block takes it
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    predicted       = apply_heap_op(kind, key);
    pending_results = {pending_results, predicted};
    request_count++;
    if (model_count > peak_count) peak_count = model_count;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: receiver idling with a long hold-off on request
  // ---------------------------------------------------------------------------
  initial rsp_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (long_hold_pending) begin
      hold_left         = LONG_HOLD;
      long_hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (!receiver_idle_on) begin
      ready_next = 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      ready_next = 1'b0;
    end else if (rx_run_left > 0) begin
      rx_run_left--;
      ready_next = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      // start an idle burst of random length that includes this call
      rx_gap_left = $urandom_range(1, 18) - 1;
      ready_next  = 1'b0;
    end else begin
      rx_run_left = $urandom_range(0, 40);
      ready_next  = 1'b1;
    end
    rsp_ch.ready <= ready_next;
  end

  // count cycles the block refuses a waiting request
  always @(posedge clk) begin
    if (!rst && req_ch.valid && !req_ch.ready) stall_cycles++;
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: min_key %0d status %0d count %0d",
               rsp_ch.min_key, rsp_ch.status, rsp_ch.entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (want.status == mhpq_pkg::STATUS_EMPTY) empty_extracts++;
        if (want.status == mhpq_pkg::STATUS_FULL) dropped_keys++;
        if (rsp_ch.min_key !== want.min_key) begin
          $error("min_key mismatch: expected %0d, actual %0d", want.min_key, rsp_ch.min_key);
          error_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, rsp_ch.entry_count);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reusable request sequences
  // ---------------------------------------------------------------------------

  // priority-queue use: inserts and extracts, size drifting around a target
  task automatic run_queue_churn(input int ops, input int target);
    int insert_pct;
    for (int n = 0; n < ops; n++) begin
      insert_pct = (model_count < target) ? 70 : 30;
      if ($urandom_range(0, 99) < insert_pct && $urandom_range(0, 7) != 0)
        send_request(mhpq_pkg::KIND_INSERT, pick_key());
      else
        send_request(mhpq_pkg::KIND_EXTRACT, pick_key());
    end
  endtask

  // bulk build: clear, raw loads, one heapify, then pull keys out
  task automatic run_bulk_build(input int loads, input int pulls);
    send_request(mhpq_pkg::KIND_CLEAR, pick_key());
    repeat (loads) send_request(mhpq_pkg::KIND_LOAD, pick_key());
    send_request(mhpq_pkg::KIND_HEAPIFY, pick_key());
    repeat (pulls) send_request(mhpq_pkg::KIND_EXTRACT, pick_key());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, ties, every kind, spare codes and the empty-heap cases
  task automatic test_directed_edges();
    send_request(mhpq_pkg::KIND_EXTRACT, KEY_MAX);       // empty heap reports an error
    send_request(mhpq_pkg::KIND_HEAPIFY, '0);            // heapify with nothing held
    send_request(mhpq_pkg::KIND_CLEAR, KEY_MIN);
    send_request(mhpq_pkg::KIND_INSERT, KEY_MAX);
    send_request(mhpq_pkg::KIND_INSERT, KEY_MIN);
    send_request(mhpq_pkg::KIND_INSERT, '0);
    send_request(mhpq_pkg::KIND_INSERT, -1);
    send_request(mhpq_pkg::KIND_INSERT, -1);             // equal keys must not swap
    send_request(mhpq_pkg::KIND_INSERT, 1);
    for (logic [3:0] k = {1'b0, KIND_SPARE_LO}; k <= {1'b0, KIND_SPARE_HI}; k++)
      send_request(k[2:0], $urandom);                    // spare kinds leave the heap alone
    repeat (6) send_request(mhpq_pkg::KIND_EXTRACT, '0); // drains in order, ties included
    send_request(mhpq_pkg::KIND_EXTRACT, '0);            // empty again after draining
    send_request(mhpq_pkg::KIND_LOAD, 5);
    send_request(mhpq_pkg::KIND_LOAD, -3);
    send_request(mhpq_pkg::KIND_LOAD, 5);
    send_request(mhpq_pkg::KIND_HEAPIFY, -1);
    send_request(mhpq_pkg::KIND_EXTRACT, KEY_MAX);
  endtask

  // fill to capacity by raw loads, overflow both append kinds, then heapify
  task automatic test_capacity_limit();
    run_bulk_build(HEAP_CAPACITY, 0);
    send_request(mhpq_pkg::KIND_LOAD, KEY_MIN);          // full: key dropped
    send_request(mhpq_pkg::KIND_INSERT, KEY_MIN);        // full: key dropped
    repeat (12) send_request(mhpq_pkg::KIND_EXTRACT, '0);
    repeat (14) send_request(mhpq_pkg::KIND_INSERT, pick_key());  // back up to full and over
    send_request(mhpq_pkg::KIND_HEAPIFY, '0);
    repeat (8) send_request(mhpq_pkg::KIND_EXTRACT, '0);
    send_request(mhpq_pkg::KIND_CLEAR, '0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    sender_idle_on    = 1'b0;
    long_hold_pending = 1'b1;
    repeat (40) send_request(mhpq_pkg::KIND_INSERT, pick_key());
    repeat (10) send_request(mhpq_pkg::KIND_EXTRACT, '0);
    sender_idle_on = 1'b1;
  endtask

  // randomized mix of well-formed sequences, broken builds and noise
  task automatic test_random_sequences(input int budget);
    int stop_at;
    int loads;
    stop_at = request_count + budget;
    while (request_count < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_queue_churn($urandom_range(8, 40), $urandom_range(1, 48));
        5, 6, 7: begin
          // mostly small builds, now and then a large one
          loads = ($urandom_range(0, 7) == 0) ? $urandom_range(100, HEAP_CAPACITY)
                                              : $urandom_range(1, 40);
          run_bulk_build(loads, (loads < 20) ? loads + $urandom_range(0, 2)
                                             : $urandom_range(1, 30));
        end
        8: begin
          // noise: any kind code, spare ones included
          repeat ($urandom_range(1, 6)) send_request(3'($urandom_range(0, 7)), $urandom);
        end
        default: begin
          // broken build: queue ops on an unordered array, heapify late or twice
          send_request(mhpq_pkg::KIND_CLEAR, pick_key());
          repeat ($urandom_range(1, 24)) send_request(mhpq_pkg::KIND_LOAD, pick_key());
          run_queue_churn($urandom_range(2, 10), 16);
          send_request(mhpq_pkg::KIND_HEAPIFY, pick_key());
          if ($urandom_range(0, 1)) send_request(mhpq_pkg::KIND_HEAPIFY, pick_key());
          repeat ($urandom_range(0, 5)) send_request(mhpq_pkg::KIND_LOAD, pick_key());
        end
      endcase
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    run_bulk_build(20, 6);
    run_queue_churn(80, 24);
  endtask

  // wait for every predicted result, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count += pending_results.size();
    end
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid     = 1'b0;
    req_ch.kind      = mhpq_pkg::KIND_INSERT;
    req_ch.key_value = '0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    model_count      = 0;
    rst              = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_capacity_limit();
    test_backpressure();
    test_random_sequences(930);
    test_full_rate_tail();

    req_ch.valid = 1'b0;
    drain_results();

    $display("covered %0d requests and %0d checked results, heap size up to %0d",
             request_count, result_count, peak_count);
    $display("empty extracts %0d, dropped keys %0d, input stall cycles %0d",
             empty_extracts, dropped_keys, stall_cycles);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #6ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_if.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_ctrl.sv
rtl/core/min_heap_priority_queue_top.sv
rtl/core/mhpq_chk.sv
tb/testbench.sv
